### sv/cursor_doubly_linked_list_defines.svh
// assertion macros for the cursor list block
`ifndef CURSOR_DOUBLY_LINKED_LIST_DEFINES_SVH
`define CURSOR_DOUBLY_LINKED_LIST_DEFINES_SVH

// a condition must imply another on the same edge
`define CDLL_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication failed");

// a condition must imply another in the cycle after it
`define CDLL_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

### sv/cdll_pkg.sv
// ----------------------------------------------------------------------------
// cdll_pkg
// shared types and codes of the cursor linked list
// ----------------------------------------------------------------------------
package cdll_pkg;

    localparam logic [3:0] CMD_CLEAR      = 4'd0;
    localparam logic [3:0] CMD_FRONT      = 4'd1;
    localparam logic [3:0] CMD_BACK       = 4'd2;
    localparam logic [3:0] CMD_PREV       = 4'd3;
    localparam logic [3:0] CMD_NEXT       = 4'd4;
    localparam logic [3:0] CMD_PREPEND    = 4'd5;
    localparam logic [3:0] CMD_APPEND     = 4'd6;
    localparam logic [3:0] CMD_INS_BEFORE = 4'd7;
    localparam logic [3:0] CMD_INS_AFTER  = 4'd8;
    localparam logic [3:0] CMD_DEL_FRONT  = 4'd9;
    localparam logic [3:0] CMD_DEL_BACK   = 4'd10;
    localparam logic [3:0] CMD_DEL_CURSOR = 4'd11;
    localparam logic [3:0] CMD_RD_FRONT   = 4'd12;
    localparam logic [3:0] CMD_RD_BACK    = 4'd13;
    localparam logic [3:0] CMD_RD_CURSOR  = 4'd14;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LINK1,
        S_LINK2,
        S_DONE
    } state_t;

endpackage

### sv/cdll_mem.sv
// ----------------------------------------------------------------------------
// cdll_mem
// synchronous memory with one write port and one registered read port
// ----------------------------------------------------------------------------
module cdll_mem #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/cursor_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list
// bounded doubly linked list with a cursor, nodes held in on-chip memories
// ----------------------------------------------------------------------------
// channel   direction  handshake        word
// command   in         start / busy     cmd, value
// result    out        done strobe      read_value, list_length,
//                                       cursor_position, status
//
// a command is taken in idle, then runs through S_READ, S_LINK1, S_LINK2, S_DONE: read
// issue, link read and first link write, value and link write, last link write with done.
// no new command is taken before done; the next start is taken on the cycle after done.
// the sequence is set by the single read port of each node memory.
// reset clears control registers only; memories need no clearing pass.
// the receiver cannot stall, so done lasts exactly one cycle.
// ----------------------------------------------------------------------------
`include "cursor_doubly_linked_list_defines.svh"

module cursor_doubly_linked_list
    import cdll_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         cmd,
    input  logic signed [31:0] value,
    output logic               done,
    output logic signed [31:0] read_value,
    output logic [8:0]         list_length,
    output logic signed [8:0]  cursor_position,
    output logic [1:0]         status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [AW:0]   NIL = {1'b1, {AW{1'b0}}};

    state_t state_reg, state_next;

    logic [3:0]            cmd_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [CW-1:0]         top_reg, top_next;
    logic [CW-1:0]         fresh_reg, fresh_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [AW-1:0]         cur_reg, cur_next;
    logic                  cval_reg, cval_next;
    logic [CW-1:0]         cidx_reg, cidx_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [AW-1:0]         new_reg, new_next;
    logic [AW-1:0]         tgt_reg, tgt_next;
    logic [1:0]            st_reg, st_next;
    logic [31:0]           rd_reg, rd_next;

    // memory ports
    logic                  v_we, n_we, p_we, f_we;
    logic [AW-1:0]         v_wa, n_wa, p_wa, f_wa;
    logic [AW-1:0]         v_ra, n_ra, p_ra, f_ra;
    logic [DATA_WIDTH-1:0] v_wd, v_rd;
    logic [AW:0]           n_wd, n_rd, p_wd, p_rd;
    logic [AW-1:0]         f_wd, f_rd;

    cdll_mem #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val (
        .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
    cdll_mem #(.WIDTH(AW + 1), .DEPTH(CAPACITY)) u_next (
        .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
    cdll_mem #(.WIDTH(AW + 1), .DEPTH(CAPACITY)) u_prev (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
    cdll_mem #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free (
        .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

    logic empty, full, at_front, at_back;
    logic [AW-1:0] n_lnk, p_lnk;

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg >= CAP);
    assign at_front = (cidx_reg == '0);
    assign at_back  = (cidx_reg == cnt_reg - CW'(1));
    assign n_lnk    = n_rd[AW-1:0];
    assign p_lnk    = p_rd[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            top_reg   <= '0;
            fresh_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            cur_reg   <= '0;
            cval_reg  <= 1'b0;
            cidx_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            fresh_reg <= fresh_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cur_reg   <= cur_next;
            cval_reg  <= cval_next;
            cidx_reg  <= cidx_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
            val_reg <= value[DATA_WIDTH-1:0];
        end
        new_reg <= new_next;
        tgt_reg <= tgt_next;
        st_reg  <= st_next;
        rd_reg  <= rd_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_READ;
            S_READ:  state_next = S_LINK1;
            S_LINK1: state_next = S_LINK2;
            S_LINK2: state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // read addresses: issued in S_READ, data valid in S_LINK1
    always_comb
    begin
        v_ra = cur_reg;
        n_ra = cur_reg;
        p_ra = cur_reg;
        f_ra = AW'(top_reg - CW'(1));
        case (cmd_reg)
            CMD_RD_FRONT, CMD_DEL_FRONT:
            begin
                v_ra = head_reg;
                n_ra = head_reg;
            end
            CMD_RD_BACK, CMD_DEL_BACK:
            begin
                v_ra = tail_reg;
                p_ra = tail_reg;
            end
            default: ;
        endcase
    end

    // datapath and memory writes
    always_comb
    begin
        top_next   = top_reg;
        fresh_next = fresh_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cur_next   = cur_reg;
        cval_next  = cval_reg;
        cidx_next  = cidx_reg;
        cnt_next   = cnt_reg;
        new_next   = new_reg;
        tgt_next   = tgt_reg;
        st_next    = st_reg;
        rd_next    = rd_reg;
        v_we = 1'b0; v_wa = new_reg; v_wd = val_reg;
        n_we = 1'b0; n_wa = new_reg; n_wd = NIL;
        p_we = 1'b0; p_wa = new_reg; p_wd = NIL;
        f_we = 1'b0; f_wa = AW'(top_reg); f_wd = tgt_reg;
        case (state_reg)
            S_READ:
            begin
                st_next = ST_OK;
                rd_next = '0;
                case (cmd_reg)
                    CMD_FRONT, CMD_BACK, CMD_DEL_FRONT, CMD_DEL_BACK,
                    CMD_RD_FRONT, CMD_RD_BACK:
                        if (empty) st_next = ST_BAD;
                    CMD_PREPEND, CMD_APPEND:
                        if (full) st_next = ST_FULL;
                    CMD_INS_BEFORE, CMD_INS_AFTER:
                        if (empty || !cval_reg) st_next = ST_BAD;
                        else if (full) st_next = ST_FULL;
                    CMD_DEL_CURSOR, CMD_RD_CURSOR:
                        if (empty || !cval_reg) st_next = ST_BAD;
                    CMD_CLEAR, CMD_PREV, CMD_NEXT: ;
                    default: st_next = ST_BAD;
                endcase
            end
            S_LINK1:
            begin
                if (st_reg == ST_OK)
                begin
                    case (cmd_reg)
                        CMD_CLEAR:
                        begin
                            top_next = '0; fresh_next = '0;
                            cnt_next = '0; cval_next = 1'b0;
                            cidx_next = '0; cur_next = '0;
                        end
                        CMD_FRONT:
                        begin
                            cval_next = 1'b1; cur_next = head_reg; cidx_next = '0;
                        end
                        CMD_BACK:
                        begin
                            cval_next = 1'b1; cur_next = tail_reg;
                            cidx_next = cnt_reg - CW'(1);
                        end
                        CMD_PREV:
                            if (cval_reg && !at_front)
                            begin
                                cidx_next = cidx_reg - CW'(1); cur_next = p_lnk;
                            end
                            else cval_next = 1'b0;
                        CMD_NEXT:
                            if (cval_reg && (cidx_reg + CW'(1) < cnt_reg))
                            begin
                                cidx_next = cidx_reg + CW'(1); cur_next = n_lnk;
                            end
                            else cval_next = 1'b0;
                        CMD_PREPEND, CMD_APPEND, CMD_INS_BEFORE, CMD_INS_AFTER:
                        begin
                            // allocate a node; its value is written in S_LINK2
                            if (top_reg != '0)
                            begin
                                top_next = top_reg - CW'(1);
                                new_next = f_rd;
                            end
                            else
                            begin
                                new_next = AW'(fresh_reg);
                                fresh_next = fresh_reg + CW'(1);
                            end
                            // remember the cursor neighbor read this cycle (prev for insert-before, else next)
                            tgt_next = (cmd_reg == CMD_INS_BEFORE) ? p_lnk : n_lnk;
                        end
                        CMD_RD_FRONT, CMD_RD_BACK, CMD_RD_CURSOR:
                            rd_next = 32'(signed'(v_rd));
                        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_CURSOR:
                        begin
                            // release the node
                            tgt_next = (cmd_reg == CMD_DEL_FRONT) ? head_reg :
                                       (cmd_reg == CMD_DEL_BACK) ? tail_reg : cur_reg;
                            if (cmd_reg == CMD_DEL_FRONT ||
                                (cmd_reg == CMD_DEL_CURSOR && at_front))
                            begin
                                if (cnt_reg <= CW'(1))
                                begin
                                    cnt_next = '0; cval_next = 1'b0;
                                    cidx_next = '0; cur_next = '0;
                                end
                                else
                                begin
                                    if (cval_reg && at_front) cval_next = 1'b0;
                                    else if (cval_reg) cidx_next = cidx_reg - CW'(1);
                                    head_next = n_lnk;
                                    cnt_next = cnt_reg - CW'(1);
                                    p_we = 1'b1; p_wa = n_lnk; p_wd = NIL;
                                end
                            end
                            else if (cmd_reg == CMD_DEL_BACK ||
                                     (cmd_reg == CMD_DEL_CURSOR && at_back))
                            begin
                                if (cnt_reg <= CW'(1))
                                begin
                                    cnt_next = '0; cval_next = 1'b0;
                                    cidx_next = '0; cur_next = '0;
                                end
                                else
                                begin
                                    if (cval_reg && at_back) cval_next = 1'b0;
                                    tail_next = p_lnk;
                                    cnt_next = cnt_reg - CW'(1);
                                    n_we = 1'b1; n_wa = p_lnk; n_wd = NIL;
                                end
                            end
                            else
                            begin
                                n_we = 1'b1; n_wa = p_lnk; n_wd = {1'b0, n_lnk};
                                p_we = 1'b1; p_wa = n_lnk; p_wd = {1'b0, p_lnk};
                                cnt_next = cnt_reg - CW'(1);
                                cval_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LINK2:
            begin
                if (st_reg == ST_OK)
                begin
                    case (cmd_reg)
                        CMD_PREPEND, CMD_APPEND, CMD_INS_BEFORE, CMD_INS_AFTER:
                        begin
                            v_we = 1'b1;
                            cnt_next = cnt_reg + CW'(1);
                            if (empty)
                            begin
                                head_next = new_reg; tail_next = new_reg;
                                n_we = 1'b1; p_we = 1'b1;
                            end
                            else if (cmd_reg == CMD_PREPEND ||
                                     (cmd_reg == CMD_INS_BEFORE && at_front))
                            begin
                                n_we = 1'b1; n_wd = {1'b0, head_reg};
                                p_we = 1'b1; p_wa = head_reg; p_wd = {1'b0, new_reg};
                                head_next = new_reg;
                                if (cval_reg) cidx_next = cidx_reg + CW'(1);
                            end
                            else if (cmd_reg == CMD_APPEND ||
                                     (cmd_reg == CMD_INS_AFTER && at_back))
                            begin
                                p_we = 1'b1; p_wd = {1'b0, tail_reg};
                                n_we = 1'b1; n_wa = tail_reg; n_wd = {1'b0, new_reg};
                                tail_next = new_reg;
                            end
                            else if (cmd_reg == CMD_INS_BEFORE)
                            begin
                                n_we = 1'b1; n_wd = {1'b0, cur_reg};
                                p_we = 1'b1; p_wd = {1'b0, tgt_reg};
                                cidx_next = cidx_reg + CW'(1);
                            end
                            else
                            begin
                                n_we = 1'b1; n_wd = {1'b0, tgt_reg};
                                p_we = 1'b1; p_wd = {1'b0, cur_reg};
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_CURSOR:
                        begin
                            if (top_reg < CAP)
                            begin
                                f_we = 1'b1;
                                top_next = top_reg + CW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DONE:
            begin
                // second link of a middle insert
                if (st_reg == ST_OK && !empty)
                begin
                    if (cmd_reg == CMD_INS_BEFORE && cidx_reg != CW'(1) &&
                        cidx_reg != '0)
                    begin
                        n_we = 1'b1; n_wa = tgt_reg; n_wd = {1'b0, new_reg};
                        p_we = 1'b1; p_wa = cur_reg; p_wd = {1'b0, new_reg};
                    end
                    else if (cmd_reg == CMD_INS_AFTER && cidx_reg + CW'(2) < cnt_reg)
                    begin
                        p_we = 1'b1; p_wa = tgt_reg; p_wd = {1'b0, new_reg};
                        n_we = 1'b1; n_wa = cur_reg; n_wd = {1'b0, new_reg};
                    end
                end
            end
            default: ;
        endcase
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = (state_reg == S_DONE);
    assign read_value      = rd_reg;
    assign list_length     = 9'(cnt_reg);
    assign cursor_position = cval_reg ? 9'(cidx_reg) : '1;
    assign status          = st_reg;

    `CDLL_ASSERT_IMPLY(a_len_cap, clk, rst_n, 1'b1, cnt_reg <= CAP)
    `CDLL_ASSERT_IMPLY(a_cur_in_range, clk, rst_n, cval_reg, cidx_reg < cnt_reg)
    `CDLL_ASSERT_NEXT(a_done_once, clk, rst_n, done, !done)
    `CDLL_ASSERT_IMPLY(a_empty_no_cursor, clk, rst_n, empty, !cval_reg)

endmodule

### verif/cursor_doubly_linked_list_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list_test
// checks the cursor list against a behavioral list kept in the bench; a
// directed opening covers empty and end-of-list cases, then random command
// sequences with bursty issue and full-pool probes compare every done word
// ----------------------------------------------------------------------------
module cursor_doubly_linked_list_test;
    import cdll_pkg::*;

    localparam int CAP = 256;
    localparam logic [3:0] CMD_UNUSED = 4'd15;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [8:0]         list_length;
        logic signed [8:0]  cursor_position;
        logic [1:0]         status;
    } res_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [3:0]         cmd = '0;
    logic signed [31:0] value = '0;
    logic               done;
    logic signed [31:0] read_value;
    logic [8:0]         list_length;
    logic signed [8:0]  cursor_position;
    logic [1:0]         status;

    cmd_word_t pending_cmds[$];
    res_word_t expected_results[$];
    int        mismatches = 0;
    int        results_seen = 0;
    int        full_hits = 0;
    bit        stim_done = 1'b0;
    bit        hold_off = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;

    // list kept as a plain array of values in order
    logic signed [31:0] list_vals[$];
    bit                 cur_ok = 1'b0;
    int                 cur_idx = 0;

    cursor_doubly_linked_list dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .value(value), .done(done), .read_value(read_value),
        .list_length(list_length), .cursor_position(cursor_position),
        .status(status)
    );

    always #4 clk = ~clk;

    function automatic res_word_t apply_list_cmd(cmd_word_t w);
        res_word_t r;
        int n;
        bit empty;
        bit full;
        r = '0;
        n = list_vals.size();
        empty = (n == 0);
        full = (n >= CAP);
        case (w.cmd)
            CMD_CLEAR: begin
                list_vals.delete();
                cur_ok = 0;
                cur_idx = 0;
            end
            CMD_FRONT, CMD_BACK: begin
                if (empty) r.status = ST_BAD;
                else begin
                    cur_ok = 1;
                    cur_idx = (w.cmd == CMD_FRONT) ? 0 : n - 1;
                end
            end
            CMD_PREV: begin
                if (cur_ok && cur_idx > 0) cur_idx--;
                else cur_ok = 0;
            end
            CMD_NEXT: begin
                if (cur_ok && cur_idx + 1 < n) cur_idx++;
                else cur_ok = 0;
            end
            CMD_PREPEND: begin
                if (full) r.status = ST_FULL;
                else begin
                    list_vals.push_front(w.value);
                    if (cur_ok) cur_idx++;
                end
            end
            CMD_APPEND: begin
                if (full) r.status = ST_FULL;
                else list_vals.push_back(w.value);
            end
            CMD_INS_BEFORE: begin
                if (empty || !cur_ok) r.status = ST_BAD;
                else if (full) r.status = ST_FULL;
                else begin
                    list_vals.insert(cur_idx, w.value);
                    cur_idx++;
                end
            end
            CMD_INS_AFTER: begin
                if (empty || !cur_ok) r.status = ST_BAD;
                else if (full) r.status = ST_FULL;
                else list_vals.insert(cur_idx + 1, w.value);
            end
            CMD_DEL_FRONT: begin
                if (empty) r.status = ST_BAD;
                else begin
                    list_vals.delete(0);
                    if (cur_ok && cur_idx == 0) cur_ok = 0;
                    else if (cur_ok) cur_idx--;
                end
            end
            CMD_DEL_BACK: begin
                if (empty) r.status = ST_BAD;
                else begin
                    if (cur_ok && cur_idx == n - 1) cur_ok = 0;
                    list_vals.delete(n - 1);
                end
            end
            CMD_DEL_CURSOR: begin
                if (empty || !cur_ok) r.status = ST_BAD;
                else begin
                    list_vals.delete(cur_idx);
                    cur_ok = 0;
                end
            end
            CMD_RD_FRONT, CMD_RD_BACK: begin
                if (empty) r.status = ST_BAD;
                else r.read_value = (w.cmd == CMD_RD_FRONT) ? list_vals[0] : list_vals[n - 1];
            end
            CMD_RD_CURSOR: begin
                if (empty || !cur_ok) r.status = ST_BAD;
                else r.read_value = list_vals[cur_idx];
            end
            default: r.status = ST_BAD;
        endcase
        if (!cur_ok) cur_idx = 0;
        if (r.status == ST_FULL) full_hits++;
        r.list_length = list_vals.size();
        r.cursor_position = cur_ok ? 9'(cur_idx) : -9'sd1;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_cmd(logic [3:0] c, logic signed [31:0] v);
        cmd_word_t w;
        w.cmd = c;
        w.value = v;
        pending_cmds.push_back(w);
    endtask

    // driver
    always @(posedge clk) begin
        if (start && !busy) begin
            expected_results.push_back(apply_list_cmd('{cmd, value}));
        end
        if (start && busy) begin
            // keep offered word until taken
        end else if (hold_off || pending_cmds.size() == 0) begin
            start <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end else begin
            cmd_word_t w;
            w = pending_cmds.pop_front();
            start <= 1'b1;
            cmd <= w.cmd;
            value <= w.value;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 30);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && done) begin
            res_word_t got;
            res_word_t want;
            got = '{read_value, list_length, cursor_position, status};
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    initial begin
        int k;
        int mode;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // directed: empty list cases, then cursor and end-of-list cases
        push_cmd(CMD_RD_FRONT, 0);
        push_cmd(CMD_RD_BACK, 0);
        push_cmd(CMD_RD_CURSOR, 0);
        push_cmd(CMD_FRONT, 0);
        push_cmd(CMD_BACK, 0);
        push_cmd(CMD_PREV, 0);
        push_cmd(CMD_NEXT, 0);
        push_cmd(CMD_INS_BEFORE, 1);
        push_cmd(CMD_DEL_FRONT, 0);
        push_cmd(CMD_DEL_BACK, 0);
        push_cmd(CMD_DEL_CURSOR, 0);
        push_cmd(CMD_UNUSED, 0);
        push_cmd(CMD_APPEND, 32'sh7fffffff);
        push_cmd(CMD_PREPEND, 32'sh80000000);
        push_cmd(CMD_APPEND, -1);
        push_cmd(CMD_FRONT, 0);
        push_cmd(CMD_PREV, 0);
        push_cmd(CMD_BACK, 0);
        push_cmd(CMD_NEXT, 0);
        push_cmd(CMD_BACK, 0);
        push_cmd(CMD_INS_AFTER, 5);
        push_cmd(CMD_INS_BEFORE, 6);
        push_cmd(CMD_RD_CURSOR, 0);
        push_cmd(CMD_DEL_CURSOR, 0);
        push_cmd(CMD_CLEAR, 0);
        // random part
        for (k = 0; k < 1000; ) begin
            mode = $urandom_range(0, 9);
            if (k == 400 || k == 900) begin
                // fill to capacity, then probe full-pool cases
                int j;
                push_cmd(CMD_CLEAR, 0);
                for (j = 0; j < CAP + 3; j++) push_cmd(CMD_APPEND, rand_word());
                push_cmd(CMD_FRONT, 0);
                push_cmd(CMD_INS_BEFORE, 1);
                push_cmd(CMD_INS_AFTER, 2);
                push_cmd(CMD_PREPEND, 3);
                push_cmd(CMD_BACK, 0);
                push_cmd(CMD_RD_CURSOR, 0);
                push_cmd(CMD_RD_BACK, 0);
                push_cmd(CMD_DEL_CURSOR, 0);
                k += 100;
            end else if (mode == 0) begin
                push_cmd(4'($urandom_range(0, 15)), rand_word());
                k++;
            end else begin
                // weighted toward growth and cursor walks
                case ($urandom_range(0, 13))
                    0, 1: push_cmd(CMD_APPEND, rand_word());
                    2: push_cmd(CMD_PREPEND, rand_word());
                    3: push_cmd($urandom_range(0, 1) ? CMD_INS_BEFORE : CMD_INS_AFTER,
                                rand_word());
                    4: push_cmd($urandom_range(0, 1) ? CMD_FRONT : CMD_BACK, 0);
                    5, 6: push_cmd($urandom_range(0, 1) ? CMD_PREV : CMD_NEXT, 0);
                    7: push_cmd(CMD_DEL_FRONT, 0);
                    8: push_cmd(CMD_DEL_BACK, 0);
                    9: push_cmd(CMD_DEL_CURSOR, 0);
                    10: push_cmd(CMD_RD_FRONT, 0);
                    11: push_cmd(CMD_RD_BACK, 0);
                    12: push_cmd(CMD_RD_CURSOR, 0);
                    default: push_cmd(($urandom_range(0, 40) == 0) ? CMD_CLEAR : CMD_NEXT,
                                      rand_word());
                endcase
                k++;
            end
            if (k == 700) begin
                // pause until the block drains
                wait (pending_cmds.size() == 0 && !start);
                hold_off = 1'b1;
                wait (expected_results.size() == 0);
                repeat (10) @(posedge clk);
                hold_off = 1'b0;
            end
        end
        wait (pending_cmds.size() == 0);
        @(posedge clk);
        while (start) @(posedge clk);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge clk);
        $display("ran %0d result words incl. %0d full-pool rejects", results_seen, full_hits);
        $display("covered empty, cursor-end, full-pool and random command mixes");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
